// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the grid interpolation block.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define TG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/tetgrid_pkg.sv =====
// Package of the tetrahedral element grid interpolation block: codes,
// sizes and fixed-point helper functions. Depends on nothing.
`default_nettype none

package tetgrid_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int MAX_GRID_EXTENT = 1024;
   localparam int NUM_WORDS       = 38;

   localparam logic [5:0] BASIS_BASE = 6'd12;
   localparam logic [5:0] VALUE_BASE = 6'd28;

   localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;
   localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRAC_BITS - 1);

   // Opcodes of an input beat.
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_POINT = 2'd1,
      OP_BOX   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_SPACING = 3'd0,
      CSR_XEXT    = 3'd1,
      CSR_YEXT    = 3'd2,
      CSR_ZEXT    = 3'd3,
      CSR_ORDER   = 3'd4
   } csr_type;

   // Result kinds.
   localparam logic KIND_BOX   = 1'b0;
   localparam logic KIND_POINT = 1'b1;

   // Clamp a wide signed value into 32 signed bits.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Higher vertex of edge node p (edges in order 10, 20, 21, 30, 31, 32).
   function automatic logic [1:0] pair_hi(input logic [2:0] p);
      logic [1:0] r;
      case (p)
         3'd0:    r = 2'd1;
         3'd1:    r = 2'd2;
         3'd2:    r = 2'd2;
         default: r = 2'd3;
      endcase
      return r;
   endfunction

   // Lower vertex of edge node p.
   function automatic logic [1:0] pair_lo(input logic [2:0] p);
      logic [1:0] r;
      case (p)
         3'd2:    r = 2'd1;
         3'd4:    r = 2'd1;
         3'd5:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/tetra_element_interp_to_grid_unit.sv =====
// Top level of the tetrahedral element grid interpolation block.
// Depends on tetgrid_pkg and assert_macros.svh.
//
// Usage: the req stream carries one beat per command, opcode in req_tuser.
// A load beat writes one element word into the 38-word element memory. A
// point beat evaluates the barycentric coordinates and the P2 (or P1)
// interpolant through one shared 32x32 multiplier; every multiply step runs a
// memory read, a multiply and an accumulate in turn, and the result then
// passes through the wait state to the output register. A box beat scans
// the four vertices per axis for their minimum and maximum and runs two
// bit-serial divisions by the spacing per axis, one for the low and one for
// the high grid bound. req_tready is high only
// while the block is idle. The result sits in the rsp output register;
// the block takes the next command while it waits there, and a second
// result holds in the block until the first has been taken. Reset clears
// the control state and loads the register defaults; element words are
// undefined until loaded. Configuration writes are taken in any cycle.
`default_nettype none
`include "assert_macros.svh"

module tetra_element_interp_to_grid_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // slot, word_value, grid_x, grid_y, grid_z, zero pad
   input  wire logic [1:0]  req_tuser,  // opcode
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // inside_res, interp_value, box_empty, box_x_low, box_x_high, box_y_low,
   // box_y_high, box_z_low, box_z_high, zero pad
   output logic [95:0]      rsp_tdata,
   output logic [0:0]       rsp_tuser,  // result_kind
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_PT, S_BMM, S_DIV, S_DQ, S_WAIT
   } state_type;

   typedef enum logic [2:0] {
      C_PT, C_LAM0, C_LAMM, C_VAL, C_SQ, C_PAIR
   } ck_type;

   // Input beat fields.
   logic [5:0]         req_slot;
   logic signed [31:0] req_word;
   logic [9:0]         req_gx, req_gy, req_gz;
   logic               req_fire;

   assign req_slot = req_tdata[5:0];
   assign req_word = req_tdata[37:6];
   assign req_gx   = req_tdata[47:38];
   assign req_gy   = req_tdata[57:48];
   assign req_gz   = req_tdata[67:58];
   assign req_fire = req_tvalid && req_tready;

   // Configuration registers.
   logic [30:0] spacing_ff;
   logic [10:0] xext_ff, yext_ff, zext_ff;
   logic        order_ff;

   // Control and datapath registers.
   state_type          state_ff;
   logic [5:0]         step_ff;
   logic [1:0]         ph_ff;
   logic [9:0]         idx_ff [0:2];
   logic signed [31:0] pt_ff [0:2];
   logic signed [31:0] lam_ff [0:3];
   logic signed [63:0] acc_ff, sum_ff, prod_ff;
   logic signed [31:0] w_ff, rdata_ff;
   logic [1:0]         axis_ff;
   logic [2:0]         cnt_ff;
   logic signed [31:0] mn_ff, mx_ff;
   logic [31:0]        quo_ff, rem_ff;
   logic [4:0]         dcnt_ff;
   logic               dsel_ff, neg_ff;
   logic signed [33:0] loq_ff;
   logic [9:0]         bl_ff [0:2];
   logic [9:0]         bh_ff [0:2];
   logic               empty_ff, kind_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_kind_ff, rsp_inside_ff, rsp_empty_ff;
   logic signed [31:0] rsp_interp_ff;
   logic [9:0]         rsp_bl_ff [0:2];
   logic [9:0]         rsp_bh_ff [0:2];

   // Element memory.
   logic signed [31:0] mem [0:tetgrid_pkg::NUM_WORDS-1];
   logic [5:0]         rd_addr;
   logic               mem_we;

   assign mem_we = req_fire && (req_tuser == tetgrid_pkg::OP_LOAD)
                   && (req_slot < 6'(tetgrid_pkg::NUM_WORDS));

   // One write port for loads, one registered read port for the sequencer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_slot] <= req_word;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Effective spacing and the current axis extent.
   logic [30:0]        dx;
   logic [10:0]        ext_raw, ext;
   logic signed [33:0] extm1;

   always_comb begin
      dx = (spacing_ff == 31'd0) ? 31'd1 : spacing_ff;
      case (axis_ff)
         2'd0:    ext_raw = xext_ff;
         2'd1:    ext_raw = yext_ff;
         default: ext_raw = zext_ff;
      endcase
      ext = (ext_raw > 11'(tetgrid_pkg::MAX_GRID_EXTENT))
            ? 11'(tetgrid_pkg::MAX_GRID_EXTENT) : ext_raw;
      extm1 = $signed({23'd0, ext}) - 34'sd1;
   end

   // Point sequencer step decode: read address, multiplier operands, use of the product.
   ck_type             ck;
   logic signed [31:0] opa, opb;
   logic [4:0]         lt;
   logic [2:0]         vt, pp;
   logic [3:0]         qt;
   logic [1:0]         rr;
   logic [5:0]         last_step;

   always_comb begin
      lt = 5'(step_ff - 6'd3);
      vt = 3'(step_ff - 6'd19);
      qt = 4'(step_ff - 6'd27);
      pp = qt[3:1];
      rr = vt[2:1];
      ck = C_PT;
      opa = '0;
      opb = '0;
      rd_addr = '0;
      last_step = order_ff ? 6'd38 : 6'd22;
      if (state_ff == S_BMM) begin
         rd_addr = 6'({cnt_ff, 1'b0}) + 6'(cnt_ff) + 6'(axis_ff);
      end else if (step_ff < 6'd3) begin
         opa = $signed({22'd0, idx_ff[step_ff[1:0]]});
         opb = $signed({1'b0, dx});
      end else if (step_ff < 6'd19) begin
         ck = (lt[1:0] == 2'd0) ? C_LAM0 : C_LAMM;
         rd_addr = tetgrid_pkg::BASIS_BASE + 6'(lt[3:0]);
         opa = rdata_ff;
         case (lt[1:0])
            2'd1:    opb = pt_ff[0];
            2'd2:    opb = pt_ff[1];
            default: opb = pt_ff[2];
         endcase
      end else if (!order_ff) begin
         ck = C_VAL;
         rd_addr = tetgrid_pkg::VALUE_BASE + 6'(vt[1:0]);
         opa = rdata_ff;
         opb = lam_ff[vt[1:0]];
      end else if (step_ff < 6'd27) begin
         if (!vt[0]) begin
            ck = C_SQ;
            opa = lam_ff[rr];
            opb = tetgrid_pkg::sat32(64'(lam_ff[rr]) - tetgrid_pkg::HALF);
         end else begin
            ck = C_VAL;
            rd_addr = tetgrid_pkg::VALUE_BASE + 6'(rr);
            opa = rdata_ff;
            opb = w_ff;
         end
      end else begin
         if (!qt[0]) begin
            ck = C_PAIR;
            opa = lam_ff[tetgrid_pkg::pair_hi(pp)];
            opb = lam_ff[tetgrid_pkg::pair_lo(pp)];
         end else begin
            ck = C_VAL;
            rd_addr = tetgrid_pkg::VALUE_BASE + 6'd4 + 6'(pp);
            opa = rdata_ff;
            opb = w_ff;
         end
      end
   end

   // Shared multiplier and product scaling.
   logic signed [63:0] prod_in, prodq, acc_in;
   assign prod_in = opa * opb;
   assign prodq   = prod_ff >>> tetgrid_pkg::FRAC_BITS;
   assign acc_in  = acc_ff + prodq;

   // Min and max over the vertices of the current axis.
   logic signed [31:0] mn_in, mx_in;
   always_comb begin
      mn_in = mn_ff;
      mx_in = mx_ff;
      if (cnt_ff == 3'd1 || rdata_ff < mn_ff) begin
         mn_in = rdata_ff;
      end
      if (cnt_ff == 3'd1 || rdata_ff > mx_ff) begin
         mx_in = rdata_ff;
      end
   end

   // Bit-serial restoring divider step.
   logic [31:0] r_sh;
   logic [32:0] diff;
   assign r_sh = {rem_ff[30:0], quo_ff[31]};
   assign diff = {1'b0, r_sh} - {2'b0, dx};

   // Rounded quotient and clipped bounds.
   logic               inc;
   logic [33:0]        mag;
   logic signed [33:0] q_in, lo_c, hi_c;
   logic               emp;
   always_comb begin
      inc  = (rem_ff != 32'd0) && (neg_ff == dsel_ff);
      mag  = {2'b0, quo_ff} + 34'(inc);
      q_in = neg_ff ? -$signed(mag) : $signed(mag);
      lo_c = (loq_ff < 34'sd0) ? 34'sd0 : loq_ff;
      hi_c = (q_in > extm1) ? extm1 : q_in;
      emp  = (ext == 11'd0) || (lo_c > hi_c);
   end

   // Inside test over the stored barycentric coordinates.
   logic pt_inside;
   assign pt_inside = !lam_ff[0][31] && !lam_ff[1][31] && !lam_ff[2][31] && !lam_ff[3][31];

   // Sequencer, configuration registers and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= 6'd0;
         rsp_valid_ff <= 1'b0;
         spacing_ff   <= 31'd65536;
         xext_ff      <= 11'd1024;
         yext_ff      <= 11'd1024;
         zext_ff      <= 11'd1024;
         order_ff     <= 1'b1;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tetgrid_pkg::CSR_SPACING: spacing_ff <= csr_wdata;
               tetgrid_pkg::CSR_XEXT:    xext_ff    <= csr_wdata[10:0];
               tetgrid_pkg::CSR_YEXT:    yext_ff    <= csr_wdata[10:0];
               tetgrid_pkg::CSR_ZEXT:    zext_ff    <= csr_wdata[10:0];
               tetgrid_pkg::CSR_ORDER:   order_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         // A taken result frees the register unless the next one moves in now.
         if (rsp_valid_ff && rsp_tready && state_ff != S_WAIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (req_tuser)
                     tetgrid_pkg::OP_POINT: begin
                        idx_ff[0] <= req_gx;
                        idx_ff[1] <= req_gy;
                        idx_ff[2] <= req_gz;
                        step_ff   <= 6'd0;
                        ph_ff     <= 2'd0;
                        sum_ff    <= 64'sd0;
                        state_ff  <= S_PT;
                     end
                     tetgrid_pkg::OP_BOX: begin
                        axis_ff  <= 2'd0;
                        cnt_ff   <= 3'd0;
                        empty_ff <= 1'b0;
                        state_ff <= S_BMM;
                     end
                     default: ;
                  endcase
               end
            end
            S_PT: begin
               case (ph_ff)
                  2'd0: ph_ff <= 2'd1;
                  2'd1: begin
                     prod_ff <= prod_in;
                     ph_ff   <= 2'd2;
                  end
                  default: begin
                     case (ck)
                        C_PT:   pt_ff[step_ff[1:0]] <= tetgrid_pkg::sat32(prod_ff);
                        C_LAM0: acc_ff <= 64'(rdata_ff);
                        C_LAMM: begin
                           acc_ff <= acc_in;
                           if (lt[1:0] == 2'd3) begin
                              lam_ff[lt[3:2]] <= tetgrid_pkg::sat32(acc_in);
                           end
                        end
                        C_VAL:  sum_ff <= sum_ff + prodq;
                        C_SQ:   w_ff <= tetgrid_pkg::sat32(
                                   64'(tetgrid_pkg::sat32(prodq)) <<< 1);
                        default: w_ff <= tetgrid_pkg::sat32(
                                   64'(tetgrid_pkg::sat32(prodq)) <<< 2);
                     endcase
                     ph_ff <= 2'd0;
                     if (step_ff == last_step) begin
                        kind_ff  <= tetgrid_pkg::KIND_POINT;
                        state_ff <= S_WAIT;
                     end else begin
                        step_ff <= step_ff + 6'd1;
                     end
                  end
               endcase
            end
            S_BMM: begin
               if (cnt_ff != 3'd0) begin
                  mn_ff <= mn_in;
                  mx_ff <= mx_in;
               end
               if (cnt_ff == 3'd4) begin
                  quo_ff   <= mn_in[31] ? (~mn_in + 32'sd1) : mn_in;
                  neg_ff   <= mn_in[31];
                  rem_ff   <= 32'd0;
                  dcnt_ff  <= 5'd0;
                  dsel_ff  <= 1'b0;
                  state_ff <= S_DIV;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_DIV: begin
               rem_ff  <= diff[32] ? r_sh : diff[31:0];
               quo_ff  <= {quo_ff[30:0], !diff[32]};
               dcnt_ff <= dcnt_ff + 5'd1;
               if (dcnt_ff == 5'd31) begin
                  state_ff <= S_DQ;
               end
            end
            S_DQ: begin
               if (!dsel_ff) begin
                  loq_ff   <= q_in;
                  quo_ff   <= mx_ff[31] ? (~mx_ff + 32'sd1) : mx_ff;
                  neg_ff   <= mx_ff[31];
                  rem_ff   <= 32'd0;
                  dcnt_ff  <= 5'd0;
                  dsel_ff  <= 1'b1;
                  state_ff <= S_DIV;
               end else begin
                  bl_ff[axis_ff] <= lo_c[9:0];
                  bh_ff[axis_ff] <= hi_c[9:0];
                  empty_ff <= empty_ff || emp;
                  if (axis_ff == 2'd2) begin
                     kind_ff  <= tetgrid_pkg::KIND_BOX;
                     state_ff <= S_WAIT;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     cnt_ff   <= 3'd0;
                     state_ff <= S_BMM;
                  end
               end
            end
            S_WAIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= kind_ff;
                  rsp_inside_ff <= kind_ff && pt_inside;
                  rsp_interp_ff <= (kind_ff && pt_inside) ? tetgrid_pkg::sat32(sum_ff) : 32'sd0;
                  rsp_empty_ff  <= !kind_ff && empty_ff;
                  for (int a = 0; a < 3; a++) begin
                     rsp_bl_ff[a] <= (kind_ff || empty_ff) ? 10'd0 : bl_ff[a];
                     rsp_bh_ff[a] <= (kind_ff || empty_ff) ? 10'd0 : bh_ff[a];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Port drive.
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {2'b00, rsp_bh_ff[2], rsp_bl_ff[2], rsp_bh_ff[1], rsp_bl_ff[1],
                        rsp_bh_ff[0], rsp_bl_ff[0], rsp_empty_ff, rsp_interp_ff,
                        rsp_inside_ff};

   // Checks on the sequencer and the result register.
   `TG_ASSERT_IMP(a_rd_in_range, clock, reset, state_ff != S_IDLE, rd_addr < 6'(tetgrid_pkg::NUM_WORDS))
   `TG_ASSERT_IMP(a_outside_zero, clock, reset, rsp_valid_ff && rsp_kind_ff && !rsp_inside_ff, rsp_interp_ff == 32'sd0)
   `TG_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid_ff && !rsp_kind_ff && rsp_empty_ff, rsp_bl_ff[0] == 10'd0 && rsp_bh_ff[0] == 10'd0 && rsp_bl_ff[2] == 10'd0)
   `TG_ASSERT_NXT(a_wait_holds, clock, reset, state_ff == S_WAIT && rsp_valid_ff && !rsp_tready, state_ff == S_WAIT)

endmodule

`default_nettype wire

// ===== sim/tetra_element_interp_to_grid_unit_test.sv =====
// Testbench of the tetrahedral element grid interpolation block.
// Drives load, point and box beats with random gaps and checks every
// result beat against a predictor kept in this file. Depends on tetgrid_pkg and tetra_element_interp_to_grid_unit.
`default_nettype none

module tetra_element_interp_to_grid_unit_test;

   localparam int CYCLE_LIMIT = 3000000;

   // One result beat as carried by the rsp stream.
   typedef struct packed {
      logic        kind;
      logic        in_elem;
      logic [31:0] value;
      logic        empty;
      logic [9:0]  xl, xh, yl, yh, zl, zh;
   } grid_result_type;

   // One row of the directed part; check_now marks a result typed in by hand.
   typedef struct {
      tetgrid_pkg::op_type op;
      logic [5:0]          slot;
      logic [31:0]         word;
      logic [9:0]          gx, gy, gz;
      bit                  check_now;
      grid_result_type     typed;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = tetgrid_pkg::OP_NONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;

   // Predictor state: element memory and register copies.
   logic signed [31:0] elem_mem [0:37];
   logic [30:0]        cfg_spacing;
   logic [10:0]        cfg_ext [0:2];
   logic               cfg_order;

   grid_result_type expected_results [$];
   int  error_count = 0;
   longint cycle_count = 0;
   bit  stall_free = 0;

   // Result side pacing: beats taken so far and the wait drawn for the next one.
   int  rsp_count = 0;
   int  rsp_seen = 0;
   int  rsp_wait = 0;

   tetra_element_interp_to_grid_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tetra_element_interp_to_grid_unit verification failed");
         $finish;
      end
   end

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Floored fixed-point product; an arithmetic shift floors directly.
   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p >>> tetgrid_pkg::FRAC_BITS;
   endfunction

   function automatic logic signed [63:0] step_size();
      return (cfg_spacing == 31'd0) ? 64'sd1 : $signed({33'd0, cfg_spacing});
   endfunction

   // Bounding box of the four vertices in grid indices, clipped to the extents.
   function automatic grid_result_type predict_box();
      grid_result_type r;
      logic signed [63:0] mn, mx, c, lo, hi, ex, dx;
      logic signed [63:0] lows [0:2];
      logic signed [63:0] highs [0:2];
      bit empty;
      r = '0;
      empty = 0;
      dx = step_size();
      for (int a = 0; a < 3; a++) begin
         mn = elem_mem[a];
         mx = elem_mem[a];
         for (int v = 1; v < 4; v++) begin
            c = elem_mem[3 * v + a];
            if (c < mn) mn = c;
            if (c > mx) mx = c;
         end
         // Signed division truncates; nudge toward ceil and floor.
         lo = mn / dx;
         if (mn % dx != 0 && mn > 0) lo = lo + 1;
         hi = mx / dx;
         if (mx % dx != 0 && mx < 0) hi = hi - 1;
         ex = $signed({53'd0, cfg_ext[a]});
         if (ex > 64'(tetgrid_pkg::MAX_GRID_EXTENT)) ex = 64'(tetgrid_pkg::MAX_GRID_EXTENT);
         if (lo < 0) lo = 0;
         if (hi > ex - 1) hi = ex - 1;
         if (ex == 0 || lo > hi) empty = 1;
         lows[a] = lo;
         highs[a] = hi;
      end
      r.kind = tetgrid_pkg::KIND_BOX;
      r.empty = empty;
      if (!empty) begin
         r.xl = lows[0][9:0];  r.xh = highs[0][9:0];
         r.yl = lows[1][9:0];  r.yh = highs[1][9:0];
         r.zl = lows[2][9:0];  r.zh = highs[2][9:0];
      end
      return r;
   endfunction

   // Barycentric coordinates of the grid point and the P1 or P2 interpolant.
   function automatic grid_result_type predict_point(input logic [9:0] gx, gy, gz);
      grid_result_type r;
      logic signed [63:0] pos [0:2];
      logic signed [63:0] lam [0:3];
      logic signed [63:0] acc, w, total, dx;
      logic [9:0] idx [0:2];
      bit ins;
      int node;
      r = '0;
      ins = 1;
      total = 0;
      dx = step_size();
      idx[0] = gx; idx[1] = gy; idx[2] = gz;
      for (int a = 0; a < 3; a++) pos[a] = clamp32($signed({54'd0, idx[a]}) * dx);
      for (int k = 0; k < 4; k++) begin
         acc = elem_mem[12 + 4 * k];
         for (int a = 0; a < 3; a++) acc = acc + fx_mul(elem_mem[13 + 4 * k + a], pos[a]);
         lam[k] = clamp32(acc);
         if (lam[k] < 0) ins = 0;
      end
      if (cfg_order == 1'b0) begin
         for (int k = 0; k < 4; k++) total = total + fx_mul(elem_mem[28 + k], lam[k]);
      end else begin
         for (int k = 0; k < 4; k++) begin
            w = clamp32(fx_mul(lam[k], clamp32(lam[k] - tetgrid_pkg::HALF)));
            w = clamp32(w * 2);
            total = total + fx_mul(elem_mem[28 + k], w);
         end
         node = 32;
         for (int j1 = 1; j1 < 4; j1++) begin
            for (int j2 = 0; j2 < j1; j2++) begin
               w = clamp32(clamp32(fx_mul(lam[j1], lam[j2])) * 4);
               total = total + fx_mul(elem_mem[node], w);
               node++;
            end
         end
      end
      r.kind = tetgrid_pkg::KIND_POINT;
      r.in_elem = ins;
      r.value = ins ? clamp32(total) : 32'd0;
      return r;
   endfunction

   // Send one beat; update the predictor and queue its result on acceptance.
   // The beat stays up after acceptance until the next one or an idle phase.
   task automatic send_beat(input tetgrid_pkg::op_type op, input logic [5:0] slot,
                            input logic [31:0] word, input logic [9:0] gx, gy, gz);
      int gap;
      gap = stall_free ? 0 : $urandom_range(0, 18);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, gz, gy, gx, word, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (op)
         tetgrid_pkg::OP_LOAD: if (slot < 6'(tetgrid_pkg::NUM_WORDS)) begin
            elem_mem[slot] = word;
         end
         tetgrid_pkg::OP_POINT: expected_results.push_back(predict_point(gx, gy, gz));
         tetgrid_pkg::OP_BOX:   expected_results.push_back(predict_box());
         default: ;
      endcase
   endtask

   // Result side: a drawn number of stalled cycles per beat.
   always @(negedge clock) begin
      if (rsp_seen != rsp_count) begin
         rsp_seen = rsp_count;
         rsp_wait = $urandom_range(0, 18);
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_free || rsp_wait == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         if (rsp_tvalid) rsp_wait = rsp_wait - 1;
      end
   end

   // Compare each taken beat against the oldest expectation.
   always @(posedge clock) begin
      grid_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         got = '0;
         got.kind    = rsp_tuser[0];
         got.in_elem = rsp_tdata[0];
         got.value   = rsp_tdata[32:1];
         got.empty   = rsp_tdata[33];
         got.xl      = rsp_tdata[43:34];
         got.xh      = rsp_tdata[53:44];
         got.yl      = rsp_tdata[63:54];
         got.yh      = rsp_tdata[73:64];
         got.zl      = rsp_tdata[83:74];
         got.zh      = rsp_tdata[93:84];
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
               error_count++;
            end
         end
      end
   end

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic write_reg(input tetgrid_pkg::csr_type idx, input logic [30:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         tetgrid_pkg::CSR_SPACING: cfg_spacing = val;
         tetgrid_pkg::CSR_XEXT:    cfg_ext[0] = val[10:0];
         tetgrid_pkg::CSR_YEXT:    cfg_ext[1] = val[10:0];
         tetgrid_pkg::CSR_ZEXT:    cfg_ext[2] = val[10:0];
         tetgrid_pkg::CSR_ORDER:   cfg_order = val[0];
         default: ;
      endcase
   endtask

   // Load a whole element: when shaped, vertex words fall near the low grid corner,
   // basis words lie between -1.0 and 1.0 and value words are random; else all are random.
   task automatic load_element(input bit shaped);
      logic signed [31:0] w;
      for (int s = 0; s < tetgrid_pkg::NUM_WORDS; s++) begin
         if (!shaped) w = $urandom;
         else if (s < 12) w = $signed($urandom_range(0, 20 << 16)) - (2 << 16);
         else if (s < 28) w = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
         else w = $urandom;
         send_beat(tetgrid_pkg::OP_LOAD, s[5:0], w, 10'($urandom), 10'($urandom),
                   10'($urandom));
      end
   endtask

   task automatic random_beat();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         send_beat(tetgrid_pkg::OP_POINT, 6'($urandom), $urandom,
                   10'($urandom_range(0, 20)), 10'($urandom_range(0, 20)),
                   10'($urandom_range(0, 20)));
      else if (pick < 60)
         send_beat(tetgrid_pkg::OP_POINT, 6'($urandom), $urandom, 10'($urandom),
                   10'($urandom), 10'($urandom));
      else if (pick < 75)
         send_beat(tetgrid_pkg::OP_BOX, 6'($urandom), $urandom, 10'($urandom),
                   10'($urandom), 10'($urandom));
      else if (pick < 92)
         send_beat(tetgrid_pkg::OP_LOAD, 6'($urandom_range(0, 37)), $urandom,
                   10'($urandom), 10'($urandom), 10'($urandom));
      else if (pick < 96)
         send_beat(tetgrid_pkg::OP_LOAD, 6'($urandom_range(38, 63)), $urandom,
                   10'($urandom), 10'($urandom), 10'($urandom));
      else
         send_beat(tetgrid_pkg::OP_NONE, 6'($urandom), $urandom, 10'($urandom),
                   10'($urandom), 10'($urandom));
   endtask

   stim_row_type directed_rows [$];

   initial begin
      stim_row_type row;
      grid_result_type got_typed;
      for (int i = 0; i < tetgrid_pkg::NUM_WORDS; i++) begin
         elem_mem[i] = 0;
      end
      cfg_spacing = 31'd65536;
      cfg_ext[0] = 11'd1024; cfg_ext[1] = 11'd1024; cfg_ext[2] = 11'd1024;
      cfg_order = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: all-zero element first, then extreme words.
      for (int s = 0; s < tetgrid_pkg::NUM_WORDS; s++) begin
         row = '{tetgrid_pkg::OP_LOAD, s[5:0], 32'd0, 10'd0, 10'd0, 10'd0, 1'b0, '0};
         directed_rows.push_back(row);
      end
      // A zero element at the origin gives a one-point box and an inside point.
      row = '{tetgrid_pkg::OP_BOX, 6'd0, 32'd0, 10'd0, 10'd0, 10'd0, 1'b1,
              '{tetgrid_pkg::KIND_BOX, 1'b0, 32'd0, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0,
                10'd0, 10'd0}};
      directed_rows.push_back(row);
      row = '{tetgrid_pkg::OP_POINT, 6'd0, 32'd0, 10'd1023, 10'd1023, 10'd1023, 1'b1,
              '{tetgrid_pkg::KIND_POINT, 1'b1, 32'd0, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0,
                10'd0, 10'd0}};
      directed_rows.push_back(row);
      row = '{tetgrid_pkg::OP_LOAD, 6'd0, 32'h7FFF_FFFF, 10'd0, 10'd0, 10'd0, 1'b0, '0};
      directed_rows.push_back(row);
      row = '{tetgrid_pkg::OP_LOAD, 6'd4, 32'h8000_0000, 10'd0, 10'd0, 10'd0, 1'b0, '0};
      directed_rows.push_back(row);
      row = '{tetgrid_pkg::OP_LOAD, 6'd12, 32'h8000_0000, 10'd0, 10'd0, 10'd0, 1'b0, '0};
      directed_rows.push_back(row);
      row = '{tetgrid_pkg::OP_LOAD, 6'd63, 32'hFFFF_FFFF, 10'd0, 10'd0, 10'd0, 1'b0, '0};
      directed_rows.push_back(row);
      row = '{tetgrid_pkg::OP_NONE, 6'd0, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 10'd1023,
              1'b0, '0};
      directed_rows.push_back(row);
      // The first lambda is hugely negative now: outside, value zero.
      row = '{tetgrid_pkg::OP_POINT, 6'd0, 32'd0, 10'd0, 10'd0, 10'd0, 1'b1,
              '{tetgrid_pkg::KIND_POINT, 1'b0, 32'd0, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0,
                10'd0, 10'd0}};
      directed_rows.push_back(row);
      row = '{tetgrid_pkg::OP_BOX, 6'd0, 32'd0, 10'd0, 10'd0, 10'd0, 1'b0, '0};
      directed_rows.push_back(row);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_beat(row.op, row.slot, row.word, row.gx, row.gy, row.gz);
         if (row.check_now && expected_results.size() != 0) begin
            got_typed = expected_results[expected_results.size() - 1];
            if (got_typed !== row.typed) begin
               $display("%0t: directed row %0d, expected %h, actual %h",
                        $time, i, row.typed, got_typed);
               error_count++;
            end
         end
      end

      // Random phases over register settings, extremes included.
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         case (phase)
            0: write_reg(tetgrid_pkg::CSR_SPACING, 31'd65536);
            1: begin
               write_reg(tetgrid_pkg::CSR_SPACING, 31'd0);
               write_reg(tetgrid_pkg::CSR_ORDER, 31'd0);
            end
            2: begin
               write_reg(tetgrid_pkg::CSR_SPACING, 31'h7FFF_FFFF);
               write_reg(tetgrid_pkg::CSR_XEXT, 31'd1);
               write_reg(tetgrid_pkg::CSR_YEXT, 31'd0);
               write_reg(tetgrid_pkg::CSR_ZEXT, 31'd2047);
            end
            3: begin
               write_reg(tetgrid_pkg::CSR_SPACING, 31'd32768);
               write_reg(tetgrid_pkg::CSR_ORDER, 31'd1);
               write_reg(tetgrid_pkg::CSR_XEXT, 31'd1024);
               write_reg(tetgrid_pkg::CSR_YEXT, 31'd7);
               write_reg(tetgrid_pkg::CSR_ZEXT, 31'd12);
            end
            4: begin
               write_reg(tetgrid_pkg::CSR_SPACING, 31'd1);
               write_reg(tetgrid_pkg::CSR_ORDER, 31'd0);
            end
            5: begin
               write_reg(tetgrid_pkg::CSR_SPACING, 31'($urandom));
               write_reg(tetgrid_pkg::CSR_XEXT, 31'($urandom_range(0, 2047)));
               write_reg(tetgrid_pkg::CSR_YEXT, 31'($urandom_range(0, 2047)));
               write_reg(tetgrid_pkg::CSR_ZEXT, 31'($urandom_range(0, 2047)));
            end
            6: begin
               write_reg(tetgrid_pkg::CSR_SPACING, 31'd131072);
               write_reg(tetgrid_pkg::CSR_ORDER, 31'd1);
               write_reg(tetgrid_pkg::CSR_YEXT, 31'd1024);
            end
            default: begin
               write_reg(tetgrid_pkg::CSR_SPACING, 31'd65536);
               write_reg(tetgrid_pkg::CSR_ZEXT, 31'd1024);
               write_reg(tetgrid_pkg::CSR_XEXT, 31'd1024);
            end
         endcase
         stall_free = (phase == 6);
         load_element(phase != 5);
         for (int k = 0; k < 110; k++) begin
            random_beat();
            if (k == 40 && phase == 3) wait_drained();
         end
         stall_free = 0;
      end

      wait_drained();
      if (error_count == 0) begin
         $display("tetra_element_interp_to_grid_unit verification clean");
      end else begin
         $display("tetra_element_interp_to_grid_unit verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/tetgrid_pkg.sv
design/tetra_element_interp_to_grid_unit.sv
sim/tetra_element_interp_to_grid_unit_test.sv
